// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg: shared constants of the buddy page allocator
// Opcodes, status codes and the fixed field widths of the request and
// result words.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

	// field widths fixed by the interface
	localparam int REQ_W  = 24;
	localparam int ADDR_W = 20;
	localparam int STAT_W = 2;
	// shift amount width of the size unit (order + page order)
	localparam int SH_W   = 6;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator: binary buddy allocator over a region of pages
// Input channel (in_valid/in_ready) takes one word: opcode, request_bytes,
// block_address. Output channel (out_valid/out_ready) returns one word per
// request: status and granted_address.
// Allocate rounds the size up to an order, scans the free-list heads,
// unlinks the head block and splits it down. Free checks the page, then
// tries buddy merges, each a read state (S_MRD) and a test state
// (S_MTST), and pushes the result. All steps share one shift/compare
// unit, and the link and page tables are read through one shared read
// address. One request is in flight at a time; after the result is
// handed to the output register the block returns to S_IDLE, where it
// takes the next word.
// After reset a clearing pass writes the page and link tables, one page
// per cycle, with in_ready low.
// A stalled receiver holds the result in the output register; the block
// then waits before loading the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator import bpa_pkg::*; #(
	parameter int PAGE_ORDER  = 12,
	parameter int TOTAL_ORDER = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              opcode,
	input  wire logic [REQ_W-1:0]  request_bytes,
	input  wire logic [ADDR_W-1:0] block_address,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [STAT_W-1:0]      status,
	output logic [ADDR_W-1:0]      granted_address
);

	localparam int PG_W   = TOTAL_ORDER - PAGE_ORDER;
	localparam int NPAGES = 1 << PG_W;
	localparam int NORD   = PG_W + 1;
	localparam int OC_W   = $clog2(NORD + 1);
	localparam int HI_W   = $clog2(NORD);
	localparam int LK_W   = PG_W + 1;
	localparam int IW     = OC_W + 1;
	localparam logic [LK_W-1:0] NIL      = LK_W'(NPAGES);
	localparam logic [OC_W-1:0] ORD_NONE = {OC_W{1'b1}};
	localparam logic [OC_W-1:0] ORD_TOP  = OC_W'(NORD - 1);
	localparam logic [IW-1:0]   INFO_NONE = {1'b0, ORD_NONE};

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_CLR   = 12'b000000000010,
		S_SIZE  = 12'b000000000100,
		S_FIND  = 12'b000000001000,
		S_UNL   = 12'b000000010000,
		S_SPLIT = 12'b000000100000,
		S_FCHK  = 12'b000001000000,
		S_MRD   = 12'b000010000000,
		S_MTST  = 12'b000100000000,
		S_PUSH  = 12'b001000000000,
		S_PUSH2 = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	logic [LK_W-1:0]   head_q [NORD];
	logic [OC_W-1:0]   ord_q, ord_d, req_q, req_d;
	logic [PG_W-1:0]   page_q, page_d, bud_q, bud_d, clr_q, clr_d;
	logic [LK_W-1:0]   old_q, old_d;
	logic [REQ_W-1:0]  bm1_q, bm1_d;
	logic              zero_q, zero_d;
	logic [STAT_W-1:0] res_st_q, res_st_d;
	logic [ADDR_W-1:0] res_ad_q, res_ad_d;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ADDR_W-1:0] granted_q;

	// tables: next link, prev link, page info {free, order}
	logic [LK_W-1:0] nx_mem [NPAGES];
	logic [LK_W-1:0] pv_mem [NPAGES];
	logic [IW-1:0]   inf_mem [NPAGES];
	logic [LK_W-1:0] nx_rd_q, pv_rd_q;
	logic [IW-1:0]   inf_rd_q;

	logic            nx_we, pv_we, inf_we;
	logic [PG_W-1:0] nx_wa, pv_wa, inf_wa, rd_a;
	logic [LK_W-1:0] nx_wd, pv_wd;
	logic [IW-1:0]   inf_wd;

	logic            head_we;
	logic [HI_W-1:0] head_wa;
	logic [LK_W-1:0] head_wd;

	logic [OC_W-1:0] u_ord, o_dec;
	logic            u_big;
	logic [PG_W-1:0] u_bud;
	logic [PG_W-1:0] in_page;
	logic [LK_W-1:0] head_cur;
	logic [TOTAL_ORDER-1:0] full_addr;
	logic            acc, out_free;

	bpa_shift_unit #(
		.PAGE_ORDER (PAGE_ORDER),
		.TOTAL_ORDER(TOTAL_ORDER)
	) u_unit (
		.bytes_m1  (bm1_q),
		.bytes_zero(zero_q),
		.ord       (u_ord),
		.page      (page_q),
		.too_big   (u_big),
		.buddy     (u_bud)
	);

	// sequencer
	always_comb begin
		state_d  = state_q;
		ord_d    = ord_q;
		req_d    = req_q;
		page_d   = page_q;
		bud_d    = bud_q;
		clr_d    = clr_q;
		old_d    = old_q;
		bm1_d    = bm1_q;
		zero_d   = zero_q;
		res_st_d = res_st_q;
		res_ad_d = res_ad_q;
		nx_we = 1'b0; nx_wa = page_q; nx_wd = NIL;
		pv_we = 1'b0; pv_wa = page_q; pv_wd = NIL;
		inf_we = 1'b0; inf_wa = page_q; inf_wd = INFO_NONE;
		head_we = 1'b0; head_wa = ord_q[HI_W-1:0]; head_wd = NIL;
		rd_a  = page_q;
		o_dec = ord_q - OC_W'(1);
		u_ord = ord_q;
		in_page  = PG_W'(block_address >> PAGE_ORDER);
		head_cur = (ord_q < OC_W'(NORD)) ? head_q[ord_q[HI_W-1:0]] : NIL;
		full_addr = {page_q, {PAGE_ORDER{1'b0}}};
		in_ready = (state_q == S_IDLE);
		acc      = in_valid && in_ready;
		out_free = !out_valid_q || out_ready;

		case (state_q)
			S_IDLE: begin
				rd_a = in_page;
				if (acc) begin
					page_d   = in_page;
					ord_d    = '0;
					bm1_d    = request_bytes - REQ_W'(1);
					zero_d   = (request_bytes == '0);
					res_st_d = ST_OK;
					res_ad_d = '0;
					state_d  = (opcode == OP_FREE) ? S_FCHK : S_SIZE;
				end
			end
			// write reset contents of the page and link tables
			S_CLR: begin
				inf_we = 1'b1;
				inf_wa = clr_q;
				inf_wd = (clr_q == '0) ? {1'b1, ORD_TOP} : INFO_NONE;
				nx_we  = 1'b1;
				nx_wa  = clr_q;
				nx_wd  = NIL;
				pv_we  = 1'b1;
				pv_wa  = clr_q;
				pv_wd  = NIL;
				clr_d  = clr_q + PG_W'(1);
				if (clr_q == {PG_W{1'b1}})
					state_d = S_IDLE;
			end
			// round size up to an order
			S_SIZE: begin
				if (ord_q >= OC_W'(NORD)) begin
					res_st_d = ST_NOSPACE;
					state_d  = S_DONE;
				end else if (u_big) begin
					ord_d = ord_q + OC_W'(1);
				end else begin
					req_d   = ord_q;
					state_d = S_FIND;
				end
			end
			// first non-empty list at or above the request
			S_FIND: begin
				rd_a = head_cur[PG_W-1:0];
				if (ord_q >= OC_W'(NORD)) begin
					res_st_d = ST_NOSPACE;
					state_d  = S_DONE;
				end else if (head_cur == NIL) begin
					ord_d = ord_q + OC_W'(1);
				end else begin
					page_d  = head_cur[PG_W-1:0];
					state_d = S_UNL;
				end
			end
			// pop the list head
			S_UNL: begin
				head_we = 1'b1;
				head_wd = nx_rd_q;
				pv_we   = !nx_rd_q[PG_W];
				pv_wa   = nx_rd_q[PG_W-1:0];
				pv_wd   = NIL;
				state_d = S_SPLIT;
			end
			// split down; lists between the requested and the found order are empty
			S_SPLIT: begin
				u_ord = o_dec;
				if (ord_q > req_q) begin
					inf_we  = 1'b1;
					inf_wa  = u_bud;
					inf_wd  = {1'b1, o_dec};
					nx_we   = 1'b1;
					nx_wa   = u_bud;
					nx_wd   = NIL;
					pv_we   = 1'b1;
					pv_wa   = u_bud;
					pv_wd   = NIL;
					head_we = 1'b1;
					head_wa = o_dec[HI_W-1:0];
					head_wd = {1'b0, u_bud};
					ord_d   = o_dec;
				end else begin
					inf_we   = 1'b1;
					inf_wd   = {1'b0, req_q};
					res_ad_d = ADDR_W'(full_addr);
					state_d  = S_DONE;
				end
			end
			// free: page must head an allocated block
			S_FCHK: begin
				if (inf_rd_q[OC_W] || inf_rd_q[OC_W-1:0] >= OC_W'(NORD)) begin
					res_st_d = ST_BADFREE;
					state_d  = S_DONE;
				end else begin
					ord_d   = inf_rd_q[OC_W-1:0];
					inf_we  = 1'b1;
					state_d = S_MRD;
				end
			end
			// fetch buddy info and links
			S_MRD: begin
				rd_a = u_bud;
				if (ord_q + OC_W'(1) >= OC_W'(NORD)) begin
					state_d = S_PUSH;
				end else begin
					bud_d   = u_bud;
					state_d = S_MTST;
				end
			end
			// merge with a free buddy of the same order
			S_MTST: begin
				if (!(inf_rd_q[OC_W] && inf_rd_q[OC_W-1:0] == ord_q)) begin
					state_d = S_PUSH;
				end else begin
					if (!pv_rd_q[PG_W]) begin
						nx_we = 1'b1;
						nx_wa = pv_rd_q[PG_W-1:0];
						nx_wd = nx_rd_q;
					end else begin
						head_we = 1'b1;
						head_wd = nx_rd_q;
					end
					pv_we  = !nx_rd_q[PG_W];
					pv_wa  = nx_rd_q[PG_W-1:0];
					pv_wd  = pv_rd_q;
					inf_we = 1'b1;
					inf_wa = bud_q;
					if (bud_q < page_q)
						page_d = bud_q;
					ord_d   = ord_q + OC_W'(1);
					state_d = S_MRD;
				end
			end
			S_PUSH: begin
				inf_we  = 1'b1;
				inf_wd  = {1'b1, ord_q};
				nx_we   = 1'b1;
				nx_wd   = head_cur;
				pv_we   = 1'b1;
				pv_wd   = NIL;
				head_we = 1'b1;
				head_wd = {1'b0, page_q};
				old_d   = head_cur;
				state_d = S_PUSH2;
			end
			S_PUSH2: begin
				pv_we   = !old_q[PG_W];
				pv_wa   = old_q[PG_W-1:0];
				pv_wd   = {1'b0, page_q};
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NORD; i++)
				head_q[i] <= (i == NORD - 1) ? LK_W'(0) : NIL;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (head_we)
				head_q[head_wa] <= head_wd;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		ord_q    <= ord_d;
		req_q    <= req_d;
		page_q   <= page_d;
		bud_q    <= bud_d;
		old_q    <= old_d;
		bm1_q    <= bm1_d;
		zero_q   <= zero_d;
		res_st_q <= res_st_d;
		res_ad_q <= res_ad_d;
		if (state_q == S_DONE && out_free) begin
			status_q  <= res_st_q;
			granted_q <= res_ad_q;
		end
	end

	// tables
	always_ff @(posedge clk) begin
		if (nx_we)
			nx_mem[nx_wa] <= nx_wd;
		nx_rd_q <= nx_mem[rd_a];
	end

	always_ff @(posedge clk) begin
		if (pv_we)
			pv_mem[pv_wa] <= pv_wd;
		pv_rd_q <= pv_mem[rd_a];
	end

	always_ff @(posedge clk) begin
		if (inf_we)
			inf_mem[inf_wa] <= inf_wd;
		inf_rd_q <= inf_mem[rd_a];
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;

	// checks
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_address == '0)
		else $error("failed request carries an address");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken during a request");

	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		ord_q <= OC_W'(NORD) || state_q == S_IDLE || state_q == S_CLR)
		else $error("order counter out of range");

	a_split_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SPLIT |-> ord_q >= req_q)
		else $error("split below requested order");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== rtl/bpa_shift_unit.sv =====
// ----------------------------------------------------------------------------
// bpa_shift_unit: shared shift and compare unit
// Tests a request size against the block size of one order, and forms
// the buddy page of a block at one order. Used once per sequencer step.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_shift_unit import bpa_pkg::*; #(
	parameter int PAGE_ORDER  = 12,
	parameter int TOTAL_ORDER = 20,
	localparam int PG_W   = TOTAL_ORDER - PAGE_ORDER,
	localparam int NORD   = PG_W + 1,
	localparam int OC_W   = $clog2(NORD + 1)
) (
	input  wire logic [REQ_W-1:0] bytes_m1,
	input  wire logic             bytes_zero,
	input  wire logic [OC_W-1:0]  ord,
	input  wire logic [PG_W-1:0]  page,
	output logic                  too_big,
	output logic [PG_W-1:0]       buddy
);

	logic [SH_W-1:0] sh;

	// size exceeds 2^(ord+PAGE_ORDER) when (size-1) has a bit at or above it
	always_comb begin
		sh      = SH_W'(ord) + SH_W'(PAGE_ORDER);
		too_big = !bytes_zero && ((bytes_m1 >> sh) != '0);
		buddy   = page ^ (PG_W'(1) << ord);
	end

endmodule

`default_nettype wire
